// ===== sv/ncc_pkg.sv =====
// Shared types, constants and a lookup function for the HSV-cone color classifier.
package ncc_pkg;

   localparam int NUM_REGS   = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int COLOR_W    = 24;
   localparam int DIST_W     = 20;
   localparam int CONE_W     = 10;
   localparam int CONE_STG   = 10;

   localparam logic [COLOR_W-1:0] REF_RESET [0:NUM_REGS-1] = '{
      24'hFF0000, 24'h00FF00, 24'h0000C8, 24'hFFFF00
   };

   // round(16384 * sin(2k deg)), k = 0..45
   localparam logic [14:0] SIN_TBL [0:45] = '{
      15'd0,     15'd572,   15'd1143,  15'd1713,  15'd2280,  15'd2845,  15'd3406,
      15'd3964,  15'd4516,  15'd5063,  15'd5604,  15'd6138,  15'd6664,  15'd7182,
      15'd7692,  15'd8192,  15'd8682,  15'd9162,  15'd9630,  15'd10087, 15'd10531,
      15'd10963, 15'd11381, 15'd11786, 15'd12176, 15'd12551, 15'd12911, 15'd13255,
      15'd13583, 15'd13894, 15'd14189, 15'd14466, 15'd14726, 15'd14968, 15'd15191,
      15'd15396, 15'd15582, 15'd15749, 15'd15897, 15'd16026, 15'd16135, 15'd16225,
      15'd16294, 15'd16344, 15'd16374, 15'd16384
   };

   typedef struct packed {
      logic [14:0] mag;
      logic        neg;
   } trig_type;

   // sin(2k deg) for k = 0..179
   function automatic trig_type trig_lookup(input logic [7:0] k);
      logic [1:0] q;
      logic [7:0] r;
      trig_type   t;
      if (k < 8'd45) begin
         q = 2'd0;
         r = k;
      end else if (k < 8'd90) begin
         q = 2'd1;
         r = k - 8'd45;
      end else if (k < 8'd135) begin
         q = 2'd2;
         r = k - 8'd90;
      end else begin
         q = 2'd3;
         r = k - 8'd135;
      end
      t.mag = q[0] ? SIN_TBL[6'(8'd45 - r)] : SIN_TBL[r[5:0]];
      t.neg = q[1];
      return t;
   endfunction

endpackage

// ===== sv/nearest_color_classifier_hsv_cone.sv =====
// Nearest reference color classifier in HSV-cone space, top level.
// One pixel per clock sustained while the output side is not stalled; each word runs through
// the 12-stage pipeline (HSV conversion with 2-bit-per-stage hue and saturation dividers,
// chroma and trig scaling, squared distances, minimum search). Each stage advances when it is
// empty or the next moves, so the input side takes words while a result waits until all stages fill.
// Reference colors run through their own free-running copies of the conversion pipeline; a
// register write takes effect for pixels accepted on any later cycle.
module nearest_color_classifier_hsv_cone #(
   parameter int NUM_REFERENCES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,  // red[7:0], green[15:8], blue[23:16]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,  // nearest_index[1:0], nearest_distance_sq[21:2]
   input  logic                            csr_we,
   input  logic [ncc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ncc_pkg::COLOR_W-1:0]     csr_wdata
);

   localparam int NSTG  = ncc_pkg::CONE_STG + 2;
   localparam int IDX_W = (NUM_REFERENCES > 1) ? $clog2(NUM_REFERENCES) : 1;

   logic [ncc_pkg::COLOR_W-1:0] ref_ff [0:ncc_pkg::NUM_REGS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ncc_pkg::NUM_REGS; i++) ref_ff[i] <= ncc_pkg::REF_RESET[i];
      end else if (csr_we && csr_addr < ncc_pkg::CSR_ADDR_W'(ncc_pkg::NUM_REGS)
                   && int'(csr_addr) < NUM_REFERENCES) begin
         ref_ff[csr_addr[1:0]] <= csr_wdata;
      end
   end

   // valid chain
   logic [NSTG-1:0] vld_ff, en;
   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || rsp_tready;
      for (int k = NSTG - 2; k >= 0; k--) en[k] = !vld_ff[k] || en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= req_tvalid;
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign req_tready = en[0];

   // pixel lane
   logic signed [ncc_pkg::CONE_W-1:0] pix_x, pix_y;
   logic [7:0]                        pix_z;

   ncc_cone u_pix (
      .clock  (clock),
      .en     (en[ncc_pkg::CONE_STG-1:0]),
      .red    (req_tdata[7:0]),
      .green  (req_tdata[15:8]),
      .blue   (req_tdata[23:16]),
      .cone_x (pix_x),
      .cone_y (pix_y),
      .cone_z (pix_z)
   );

   // reference lanes and distances
   logic [ncc_pkg::DIST_W-1:0] d_ff [0:NUM_REFERENCES-1];

   for (genvar i = 0; i < NUM_REFERENCES; i++) begin : g_ref
      logic [ncc_pkg::COLOR_W-1:0]       col;
      logic signed [ncc_pkg::CONE_W-1:0] rx, ry;
      logic [7:0]                        rz;
      logic signed [10:0]                dx, dy, dz;
      logic [21:0]                       sq;

      if (i < ncc_pkg::NUM_REGS) begin : g_reg
         assign col = ref_ff[i];
      end else begin : g_black
         assign col = '0;
      end

      ncc_cone u_ref (
         .clock  (clock),
         .en     ({ncc_pkg::CONE_STG{1'b1}}),
         .red    (col[23:16]),
         .green  (col[15:8]),
         .blue   (col[7:0]),
         .cone_x (rx),
         .cone_y (ry),
         .cone_z (rz)
      );

      assign dx = 11'(pix_x) - 11'(rx);
      assign dy = 11'(pix_y) - 11'(ry);
      assign dz = $signed({3'd0, pix_z}) - $signed({3'd0, rz});
      assign sq = 22'(dx * dx) + 22'(dy * dy) + 22'(dz * dz);

      always_ff @(posedge clock) begin
         if (en[NSTG-2]) d_ff[i] <= sq[ncc_pkg::DIST_W-1:0];
      end
   end

   // minimum search, lowest index wins ties
   logic [IDX_W-1:0]           best_c;
   logic [ncc_pkg::DIST_W-1:0] bestd_c;
   always_comb begin
      best_c  = '0;
      bestd_c = d_ff[0];
      for (int i = 1; i < NUM_REFERENCES; i++) begin
         if (d_ff[i] < bestd_c) begin
            bestd_c = d_ff[i];
            best_c  = IDX_W'(i);
         end
      end
   end

   logic [1:0]                 idx_ff;
   logic [ncc_pkg::DIST_W-1:0] dist_ff;
   logic [2:0]                 best3_c;
   assign best3_c = 3'(best_c);

   always_ff @(posedge clock) begin
      if (en[NSTG-1]) begin
         idx_ff  <= best3_c[1:0];
         dist_ff <= bestd_c;
      end
   end

   assign rsp_tvalid = vld_ff[NSTG-1];
   assign rsp_tdata  = {2'b00, dist_ff, idx_ff};

endmodule

// ===== sv/ncc_cone.sv =====
// RGB to HSV-cone point conversion pipeline, ten register stages with per-stage enables.
module ncc_cone (
   input  logic                              clock,
   input  logic [ncc_pkg::CONE_STG-1:0]      en,
   input  logic [7:0]                        red,
   input  logic [7:0]                        green,
   input  logic [7:0]                        blue,
   output logic signed [ncc_pkg::CONE_W-1:0] cone_x,
   output logic signed [ncc_pkg::CONE_W-1:0] cone_y,
   output logic [7:0]                        cone_z
);

   typedef struct packed {
      logic [16:0] n;
      logic [1:0]  q;
   } dstep_type;

   // two restoring-division quotient bits, hi and hi-1
   function automatic dstep_type div_step(input logic [16:0] n, input logic [8:0] d,
                                          input int hi);
      dstep_type   o;
      logic [16:0] ds;
      o.n = n;
      o.q = 2'b00;
      ds  = 17'({8'd0, d} << hi);
      if (o.n >= ds) begin
         o.n    = o.n - ds;
         o.q[1] = 1'b1;
      end
      ds = 17'({8'd0, d} << (hi - 1));
      if (o.n >= ds) begin
         o.n    = o.n - ds;
         o.q[0] = 1'b1;
      end
      return o;
   endfunction

   // stage 1
   logic [7:0]         v_c, mn_c, diff_c;
   logic signed [11:0] num_c;
   logic [16:0]        nh_ff [0:4];
   logic [16:0]        ns_ff [0:4];
   logic [8:0]         dh_ff [0:4];
   logic [8:0]         ds_ff [0:4];
   logic [7:0]         qh_ff [0:4];
   logic [7:0]         qs_ff [0:4];
   logic [7:0]         v_ff  [0:4];
   logic               hz_ff [0:4];
   logic               sz_ff [0:4];

   always_comb begin
      v_c  = red;
      mn_c = red;
      if (green > v_c) v_c = green;
      if (blue > v_c) v_c = blue;
      if (green < mn_c) mn_c = green;
      if (blue < mn_c) mn_c = blue;
      diff_c = v_c - mn_c;
      if (v_c == red) begin
         num_c = $signed({4'd0, green}) - $signed({4'd0, blue});
      end else if (v_c == green) begin
         num_c = $signed({4'd0, blue}) - $signed({4'd0, red}) + $signed({3'd0, diff_c, 1'b0});
      end else begin
         num_c = $signed({4'd0, red}) - $signed({4'd0, green}) + $signed({2'd0, diff_c, 2'b0});
      end
      if (num_c < 0) num_c = num_c + $signed(12'(diff_c * 6));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         nh_ff[0] <= 17'(num_c[10:0] * 60) + 17'(diff_c);
         dh_ff[0] <= {diff_c, 1'b0};
         ns_ff[0] <= 17'(diff_c * 510) + 17'(v_c);
         ds_ff[0] <= {v_c, 1'b0};
         qh_ff[0] <= 8'd0;
         qs_ff[0] <= 8'd0;
         v_ff[0]  <= v_c;
         hz_ff[0] <= (diff_c == 8'd0);
         sz_ff[0] <= (v_c == 8'd0);
      end
   end

   // stages 2..5: hue and saturation dividers, two bits a stage
   for (genvar j = 1; j <= 4; j++) begin : g_div
      dstep_type sh_c, ss_c;
      assign sh_c = div_step(nh_ff[j-1], dh_ff[j-1], 9 - 2 * j);
      assign ss_c = div_step(ns_ff[j-1], ds_ff[j-1], 9 - 2 * j);
      always_ff @(posedge clock) begin
         if (en[j]) begin
            nh_ff[j] <= sh_c.n;
            ns_ff[j] <= ss_c.n;
            dh_ff[j] <= dh_ff[j-1];
            ds_ff[j] <= ds_ff[j-1];
            qh_ff[j] <= qh_ff[j-1] | 8'({sh_c.q} << (8 - 2 * j));
            qs_ff[j] <= qs_ff[j-1] | 8'({ss_c.q} << (8 - 2 * j));
            v_ff[j]  <= v_ff[j-1];
            hz_ff[j] <= hz_ff[j-1];
            sz_ff[j] <= sz_ff[j-1];
         end
      end
   end

   // stage 6: hue wrap, gray and black cases
   logic [7:0] h6_ff, s6_ff, v6_ff;
   always_ff @(posedge clock) begin
      if (en[5]) begin
         h6_ff <= (hz_ff[4] || qh_ff[4] >= 8'd180) ? 8'd0 : qh_ff[4];
         s6_ff <= sz_ff[4] ? 8'd0 : qs_ff[4];
         v6_ff <= v_ff[4];
      end
   end

   // stage 7: V*S product, trig lookups
   logic [7:0]          kx_c;
   ncc_pkg::trig_type   tx_c, ty_c;
   logic [15:0]         p7_ff;
   ncc_pkg::trig_type   tx7_ff, ty7_ff, tx8_ff, ty8_ff, tx9_ff, ty9_ff;
   logic [7:0]          v7_ff, v8_ff, v9_ff;

   assign kx_c = (h6_ff >= 8'd135) ? h6_ff - 8'd135 : h6_ff + 8'd45;
   assign tx_c = ncc_pkg::trig_lookup(kx_c);
   assign ty_c = ncc_pkg::trig_lookup(h6_ff);

   always_ff @(posedge clock) begin
      if (en[6]) begin
         p7_ff  <= h6_ff == h6_ff ? 16'(v6_ff * s6_ff) : 16'd0;
         tx7_ff <= tx_c;
         ty7_ff <= ty_c;
         v7_ff  <= v6_ff;
      end
   end

   // stage 8: chroma estimate by reciprocal of 510
   logic [16:0] t_c, t8_ff;
   logic [8:0]  q8_ff;
   logic [30:0] qm_c;
   assign t_c  = {p7_ff, 1'b0} + 17'd255;
   assign qm_c = 31'(t_c * 14'd8225);

   always_ff @(posedge clock) begin
      if (en[7]) begin
         t8_ff  <= t_c;
         q8_ff  <= qm_c[30:22];
         tx8_ff <= tx7_ff;
         ty8_ff <= ty7_ff;
         v8_ff  <= v7_ff;
      end
   end

   // stage 9: correction step
   logic [7:0]  c9_ff;
   logic [17:0] qb_c;
   assign qb_c = 18'(q8_ff * 9'd510);

   always_ff @(posedge clock) begin
      if (en[8]) begin
         c9_ff  <= (qb_c > {1'b0, t8_ff}) ? 8'(q8_ff - 9'd1) : q8_ff[7:0];
         tx9_ff <= tx8_ff;
         ty9_ff <= ty8_ff;
         v9_ff  <= v8_ff;
      end
   end

   // stage 10: scale chroma by trig magnitude
   logic [22:0] px_c, py_c;
   logic [8:0]  mx_c, my_c;
   logic signed [ncc_pkg::CONE_W-1:0] x_ff, y_ff;
   logic [7:0]  z_ff;
   assign px_c = 23'(c9_ff * tx9_ff.mag) + 23'd8192;
   assign py_c = 23'(c9_ff * ty9_ff.mag) + 23'd8192;
   assign mx_c = px_c[22:14];
   assign my_c = py_c[22:14];

   always_ff @(posedge clock) begin
      if (en[9]) begin
         x_ff <= tx9_ff.neg ? -$signed({1'b0, mx_c}) : $signed({1'b0, mx_c});
         y_ff <= ty9_ff.neg ? -$signed({1'b0, my_c}) : $signed({1'b0, my_c});
         z_ff <= v9_ff;
      end
   end

   assign cone_x = x_ff;
   assign cone_y = y_ff;
   assign cone_z = z_ff;

endmodule

// ===== sv/ncc_checker.sv =====
// Port-level checker for the classifier, bound to the top level.
module ncc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:22] == 2'b00)
      else $error("result padding bits not zero");

   a_dist_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[21:2] <= 20'd585225)
      else $error("distance out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

   a_no_early: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word right after reset");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input blocked while output side moves");

endmodule

bind nearest_color_classifier_hsv_cone ncc_checker u_ncc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
